/* hdl/npa_pkg.sv */
// Shared types, constants and command/status structs for the NAT port pool allocator.
// Used by npa_ctrl, npa_datapath and nat_port_pool_allocator_core; depends on nothing.
package npa_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int PROTO_W   = 8;
    localparam int SPAN_W    = PORT_W + 1;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PORT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_BEGIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_END       = 2'd2;

    localparam logic [PORT_W-1:0] PORT_BEGIN_RESET = 16'd1024;
    localparam logic [PORT_W-1:0] PORT_END_RESET   = 16'd2047;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [PROTO_W-1:0]   protocol;
        logic [PORT_W-1:0]    port;
        logic [ADDR_W-1:0]    address;
    } map_entry_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic clear_start;
        logic clear_step;
    } npa_cmd_t;

    typedef struct packed {
        logic bound_write;
        logic clear_last;
    } npa_status_t;

endpackage

/* hdl/npa_ctrl.sv */
// Controller state machine of the NAT port pool allocator.
// Depends on npa_pkg; drives the command struct for npa_datapath.
module npa_ctrl
    import npa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  npa_status_t status_in,
    output npa_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE) || status_in.bound_write;
        if (status_in.bound_write)
        begin
            cmd.clear_start = 1'b1;
            state_next      = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    cmd.clear_step = 1'b1;
                    if (status_in.clear_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (!(out_valid_reg && out_stall))
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_CLEAR;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/npa_datapath.sv */
// Datapath of the NAT port pool allocator: configuration, pool counters, recycle ring,
// mapping memory and result registers. Depends on npa_pkg; steered by npa_ctrl.
module npa_datapath
    import npa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  npa_cmd_t              cmd,
    output npa_status_t           status_out,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    input  logic [OP_W-1:0]       operation,
    input  logic [ADDR_W-1:0]     private_address,
    input  logic [PORT_W-1:0]     private_port,
    input  logic [PROTO_W-1:0]    protocol,
    input  logic [ADDR_W-1:0]     external_address,
    input  logic [PORT_W-1:0]     external_port,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     granted_address,
    output logic [PORT_W-1:0]     granted_port,
    output logic [PROTO_W-1:0]    granted_protocol,
    output logic [ADDR_W-1:0]     found_address,
    output logic [PORT_W-1:0]     found_port
);

    logic [ADDR_W-1:0]  public_address_reg;
    logic [PORT_W-1:0]  port_begin_reg;
    logic [PORT_W-1:0]  port_end_reg;

    logic [CNT_W-1:0]   fresh_next_reg;
    logic [CNT_W-1:0]   fresh_next_next;
    logic [IDX_W-1:0]   recycle_head_reg;
    logic [IDX_W-1:0]   recycle_head_next;
    logic [CNT_W-1:0]   recycle_count_reg;
    logic [CNT_W-1:0]   recycle_count_next;
    logic [IDX_W-1:0]   clear_cnt_reg;

    logic [OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]  paddr_reg;
    logic [PORT_W-1:0]  pport_reg;
    logic [PROTO_W-1:0] proto_reg;
    logic [ADDR_W-1:0]  eaddr_reg;
    logic [PORT_W-1:0]  eport_reg;

    map_entry_t         map_mem_reg [POOL_SIZE];
    map_entry_t         map_rd_reg;
    logic [IDX_W-1:0]   ring_mem_reg [POOL_SIZE];
    logic [IDX_W-1:0]   ring_rd_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   granted_address_reg;
    logic [PORT_W-1:0]   granted_port_reg;
    logic [PROTO_W-1:0]  granted_protocol_reg;
    logic [ADDR_W-1:0]   found_address_reg;
    logic [PORT_W-1:0]   found_port_reg;

    logic                bound_write;
    logic [SPAN_W-1:0]   span;
    logic [CNT_W-1:0]    pool_size;
    logic [PORT_W-1:0]   in_offset;
    logic [PORT_W-1:0]   item_offset;
    logic [IDX_W-1:0]    map_raddr;
    logic                fresh_avail;
    logic                recycle_avail;
    logic                reserve_ok;
    logic [IDX_W-1:0]    reserve_idx;
    logic                live_match;
    logic [CNT_W:0]      tail_sum;
    logic [IDX_W-1:0]    tail_idx;
    logic [CNT_W-1:0]    head_inc;
    logic                map_we;
    logic [IDX_W-1:0]    map_waddr;
    map_entry_t          map_wdata;
    logic                ring_we;

    logic [STATUS_W-1:0] res_status;
    logic [ADDR_W-1:0]   res_granted_address;
    logic [PORT_W-1:0]   res_granted_port;
    logic [PROTO_W-1:0]  res_granted_protocol;
    logic [ADDR_W-1:0]   res_found_address;
    logic [PORT_W-1:0]   res_found_port;

    assign bound_write = cfg_write
        && ((cfg_index == REG_PORT_BEGIN) || (cfg_index == REG_PORT_END));

    assign status_out.bound_write = bound_write;
    assign status_out.clear_last  = (clear_cnt_reg == IDX_W'(POOL_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            public_address_reg <= '0;
            port_begin_reg     <= PORT_BEGIN_RESET;
            port_end_reg       <= PORT_END_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_PUBLIC_ADDRESS)
            begin
                public_address_reg <= cfg_data;
            end
            if (cfg_index == REG_PORT_BEGIN)
            begin
                port_begin_reg <= cfg_data[PORT_W-1:0];
            end
            if (cfg_index == REG_PORT_END)
            begin
                port_end_reg <= cfg_data[PORT_W-1:0];
            end
        end
    end

    always_comb
    begin
        span = {1'b0, port_end_reg} - {1'b0, port_begin_reg} + SPAN_W'(1);
        if (port_end_reg < port_begin_reg)
        begin
            pool_size = '0;
        end
        else if (span > SPAN_W'(POOL_SIZE))
        begin
            pool_size = CNT_W'(POOL_SIZE);
        end
        else
        begin
            pool_size = span[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            paddr_reg <= private_address;
            pport_reg <= private_port;
            proto_reg <= protocol;
            eaddr_reg <= external_address;
            eport_reg <= external_port;
        end
    end

    assign in_offset   = external_port - port_begin_reg;
    assign item_offset = eport_reg - port_begin_reg;
    assign map_raddr   = cmd.load ? in_offset[IDX_W-1:0] : item_offset[IDX_W-1:0];

    always_comb
    begin
        fresh_avail   = fresh_next_reg < pool_size;
        recycle_avail = recycle_count_reg != '0;
        reserve_ok    = fresh_avail || recycle_avail;
        reserve_idx   = fresh_avail ? fresh_next_reg[IDX_W-1:0] : ring_rd_reg;
        live_match    = (eaddr_reg == public_address_reg)
            && (eport_reg >= port_begin_reg)
            && (SPAN_W'(item_offset) < SPAN_W'(pool_size))
            && map_rd_reg.valid
            && (map_rd_reg.protocol == proto_reg);
        tail_sum = (CNT_W + 1)'(recycle_head_reg) + (CNT_W + 1)'(recycle_count_reg);
        if (tail_sum >= (CNT_W + 1)'(POOL_SIZE))
        begin
            tail_sum = tail_sum - (CNT_W + 1)'(POOL_SIZE);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        head_inc = CNT_W'(recycle_head_reg) + CNT_W'(1);
        if (head_inc == CNT_W'(POOL_SIZE))
        begin
            head_inc = '0;
        end
    end

    always_comb
    begin
        res_status           = STATUS_NO_MATCH;
        res_granted_address  = '0;
        res_granted_port     = '0;
        res_granted_protocol = '0;
        res_found_address    = '0;
        res_found_port       = '0;
        fresh_next_next      = fresh_next_reg;
        recycle_head_next    = recycle_head_reg;
        recycle_count_next   = recycle_count_reg;
        map_we               = 1'b0;
        map_waddr            = clear_cnt_reg;
        map_wdata            = '0;
        ring_we              = 1'b0;
        unique case (op_reg)
            OP_RESERVE:
            begin
                if (reserve_ok)
                begin
                    res_status           = STATUS_OK;
                    res_granted_address  = public_address_reg;
                    res_granted_port     = port_begin_reg + PORT_W'(reserve_idx);
                    res_granted_protocol = proto_reg;
                    map_we               = cmd.commit;
                    map_waddr            = reserve_idx;
                    map_wdata.valid      = 1'b1;
                    map_wdata.protocol   = proto_reg;
                    map_wdata.port       = pport_reg;
                    map_wdata.address    = paddr_reg;
                    if (cmd.commit)
                    begin
                        if (fresh_avail)
                        begin
                            fresh_next_next = fresh_next_reg + CNT_W'(1);
                        end
                        else
                        begin
                            recycle_head_next  = head_inc[IDX_W-1:0];
                            recycle_count_next = recycle_count_reg - CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    res_status = STATUS_NO_PORT;
                end
            end
            OP_RELEASE:
            begin
                if (live_match)
                begin
                    res_status      = STATUS_OK;
                    map_we          = cmd.commit;
                    map_waddr       = item_offset[IDX_W-1:0];
                    map_wdata       = map_rd_reg;
                    map_wdata.valid = 1'b0;
                    if (cmd.commit && (recycle_count_reg < CNT_W'(POOL_SIZE)))
                    begin
                        ring_we            = 1'b1;
                        recycle_count_next = recycle_count_reg + CNT_W'(1);
                    end
                end
            end
            OP_LOOKUP:
            begin
                if (live_match)
                begin
                    res_status        = STATUS_OK;
                    res_found_address = map_rd_reg.address;
                    res_found_port    = map_rd_reg.port;
                end
            end
            default:
            begin
                res_status = STATUS_NO_MATCH;
            end
        endcase
        if (cmd.clear_step)
        begin
            map_we    = 1'b1;
            map_waddr = clear_cnt_reg;
            map_wdata = '0;
        end
        if (bound_write)
        begin
            fresh_next_next    = '0;
            recycle_head_next  = '0;
            recycle_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_next_reg    <= '0;
            recycle_head_reg  <= '0;
            recycle_count_reg <= '0;
            clear_cnt_reg     <= '0;
        end
        else
        begin
            fresh_next_reg    <= fresh_next_next;
            recycle_head_reg  <= recycle_head_next;
            recycle_count_reg <= recycle_count_next;
            if (cmd.clear_start)
            begin
                clear_cnt_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem_reg[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem_reg[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem_reg[tail_idx] <= item_offset[IDX_W-1:0];
        end
        ring_rd_reg <= ring_mem_reg[recycle_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg           <= res_status;
            granted_address_reg  <= res_granted_address;
            granted_port_reg     <= res_granted_port;
            granted_protocol_reg <= res_granted_protocol;
            found_address_reg    <= res_found_address;
            found_port_reg       <= res_found_port;
        end
    end

    assign status           = status_reg;
    assign granted_address  = granted_address_reg;
    assign granted_port     = granted_port_reg;
    assign granted_protocol = granted_protocol_reg;
    assign found_address    = found_address_reg;
    assign found_port       = found_port_reg;

endmodule

/* hdl/nat_port_pool_allocator_core.sv */
// Top level of the NAT port pool allocator: joins npa_ctrl and npa_datapath.
// Depends on npa_pkg, npa_ctrl and npa_datapath.
//
// Each word is accepted in the idle state, in which the mapping memory and the
// recycle ring are read, and then executes in the execute state, in which the
// result is registered and the memories are written back; execution waits while
// the output register still holds a stalled result. A finished result waits in
// the output register while the next word is accepted. After reset, and after
// every write to port_begin or port_end, a clearing pass invalidates all mappings
// and stalls input words until it ends; configuration writes are always accepted.
module nat_port_pool_allocator_core
    import npa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [ADDR_W-1:0]     private_address,
    input  logic [PORT_W-1:0]     private_port,
    input  logic [PROTO_W-1:0]    protocol,
    input  logic [ADDR_W-1:0]     external_address,
    input  logic [PORT_W-1:0]     external_port,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     granted_address,
    output logic [PORT_W-1:0]     granted_port,
    output logic [PROTO_W-1:0]    granted_protocol,
    output logic [ADDR_W-1:0]     found_address,
    output logic [PORT_W-1:0]     found_port
);

    npa_cmd_t    cmd;
    npa_status_t dp_status;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    npa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status_in (dp_status),
        .cmd       (cmd)
    );

    npa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status_out       (dp_status),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .private_address  (private_address),
        .private_port     (private_port),
        .protocol         (protocol),
        .external_address (external_address),
        .external_port    (external_port),
        .status           (status),
        .granted_address  (granted_address),
        .granted_port     (granted_port),
        .granted_protocol (granted_protocol),
        .found_address    (found_address),
        .found_port       (found_port)
    );

`ifndef ASSERT_OFF
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("Result committed while the output register was still held.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("A second word was accepted before the first one executed.");

    a_clear_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> in_stall)
        else $error("Input word accepted during the clearing pass.");

    a_commit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.load && !cmd.clear_step)
        else $error("Commit overlaps a load or a clearing step.");
`endif

endmodule
